/* rtl/core/htm_pkg.sv */
// htm_pkg: shared types, constants and the exp2 coefficient function of the
// tone-mapping block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package htm_pkg;

    // Pipeline depth of the arithmetic per channel
    localparam int DIV_STEPS  = 16;
    localparam int SQ_STEPS   = 16;
    localparam int EXP_STEPS  = 16;
    localparam int CH_LATENCY = 6 + DIV_STEPS + SQ_STEPS + EXP_STEPS;

    // Classified-item queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_DATA_W = 24;

    typedef enum logic [0:0] {
        REG_SCALE = 1'b0,
        REG_GAMMA = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic signed [31:0] red_in;
        logic signed [31:0] green_in;
        logic signed [31:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       range_error;
    } pix_out_t;

    // Classified item: magnitudes, cleared when any channel was negative
    typedef struct packed {
        logic        neg;
        logic [30:0] red;
        logic [30:0] green;
        logic [30:0] blue;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Integer square root, bit by bit (elaboration only)
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] op;
        logic [63:0] res;
        logic [63:0] one;
        int          i;
        op  = v;
        res = '0;
        one = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++) begin
            if (one > op)
                one = one >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (one != 64'd0) begin
                if (op >= res + one) begin
                    op  = op - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
        end
        return res;
    endfunction

    // Coefficient for fraction bit of weight 2^-(k+1): about 2^(-2^-(k+1)) in Q0.30
    function automatic logic [29:0] exp_coef(input int k);
        logic [63:0] t;
        int          j;
        t = isqrt64(64'd1 << 59);
        for (j = 1; j <= k; j++)
            t = isqrt64(t << 30);
        return t[29:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/htm_front.sv */
// htm_front: input register that takes pixels and classifies them (sign check)
// before they enter the queue. Depends on htm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htm_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire htm_pkg::pix_in_t   in_data,
    input  wire htm_pkg::q_status_t q_st,
    output logic                    q_push,
    output htm_pkg::item_t          q_item
);

    logic           fr_valid_reg;
    logic           fr_valid_next;
    htm_pkg::item_t fr_item_reg;
    htm_pkg::item_t fr_item_next;
    logic           accept;
    logic           neg;

    // Hold the item while the queue is full
    assign in_stall = fr_valid_reg && q_st.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = fr_valid_reg && !q_st.full;
    assign q_item   = fr_item_reg;

    // Classify: a negative channel clears all magnitudes
    always_comb
    begin
        neg = in_data.red_in[31] | in_data.green_in[31] | in_data.blue_in[31];
        fr_item_next.neg   = neg;
        fr_item_next.red   = neg ? '0 : in_data.red_in[30:0];
        fr_item_next.green = neg ? '0 : in_data.green_in[30:0];
        fr_item_next.blue  = neg ? '0 : in_data.blue_in[30:0];
    end

    always_comb
    begin
        if (accept)
            fr_valid_next = 1'b1;
        else if (q_push)
            fr_valid_next = 1'b0;
        else
            fr_valid_next = fr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fr_item_reg <= fr_item_next;
    end

endmodule
`default_nettype wire

/* rtl/core/htm_queue.sv */
// htm_queue: short FIFO of classified items between front and back.
// Depends on htm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire htm_pkg::item_t  push_item,
    input  wire logic            pop,
    output htm_pkg::item_t       head,
    output htm_pkg::q_status_t   st
);

    htm_pkg::item_t                  mem_reg [htm_pkg::Q_DEPTH];
    logic [htm_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [htm_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [htm_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [htm_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [htm_pkg::Q_CNT_W-1:0]     cnt_reg;
    logic [htm_pkg::Q_CNT_W-1:0]     cnt_next;

    assign st.full  = (cnt_reg == htm_pkg::Q_CNT_W'(htm_pkg::Q_DEPTH));
    assign st.empty = (cnt_reg == '0);
    assign head     = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

/* rtl/core/htm_chan.sv */
// htm_chan: arithmetic pipeline of one channel: scale, Reinhard divide,
// log2 by squaring, gamma, exp2 by coefficients, 8-bit output. Depends on htm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htm_chan #(
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] x,
    input  wire logic [23:0] scale,
    input  wire logic [15:0] gamma,
    output logic [7:0]       y
);

    localparam int          DIV  = htm_pkg::DIV_STEPS;
    localparam int          SQ   = htm_pkg::SQ_STEPS;
    localparam int          EXPN = htm_pkg::EXP_STEPS;
    localparam logic [31:0] BIAS = 32'(64'd1 << PIXEL_FRAC_BITS);

    // ---- scale and saturate
    logic [54:0] s_prod;
    logic [30:0] s_reg;
    logic [30:0] s_next;

    always_comb
    begin
        s_prod = 55'(x) * 55'(scale);
        s_next = (|s_prod[54:47]) ? 31'h7FFF_FFFF : s_prod[46:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_reg <= s_next;
    end

    // ---- divider set-up: remainder starts at s, divisor s + 2^frac
    logic [31:0] rem_reg [DIV];
    logic [31:0] d_reg   [DIV];
    logic [15:0] q_reg   [1:DIV];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, s_reg};
            d_reg[0]   <= {1'b0, s_reg} + BIAS;
        end
    end

    // ---- restoring divide, one quotient bit per stage
    for (genvar i = 0; i < DIV; i++)
    begin : g_div
        logic [32:0] rem2;
        logic [32:0] diff;
        logic        ge;
        logic [15:0] q_in;

        always_comb
        begin
            rem2 = {rem_reg[i], 1'b0};
            diff = rem2 - {1'b0, d_reg[i]};
            ge   = (rem2 >= {1'b0, d_reg[i]});
        end

        if (i == 0)
        begin : g_q0
            assign q_in = '0;
        end
        else
        begin : g_qn
            assign q_in = q_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                q_reg[i+1] <= {q_in[14:0], ge};
        end

        if (i < DIV - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[31:0] : rem2[31:0];
                    d_reg[i+1]   <= d_reg[i];
                end
            end
        end
    end

    // ---- normalise: leading one position and mantissa in Q1.15
    logic [15:0] z_reg  [SQ];
    logic [15:0] fr_reg [1:SQ];
    logic [4:0]  hi_reg [SQ+1];
    logic        zf_reg [SQ+1];
    logic [3:0]  lead;
    logic [15:0] cq;

    always_comb
    begin
        cq   = q_reg[DIV];
        lead = '0;
        for (int j = 0; j < 16; j++)
        begin
            if (cq[j])
                lead = 4'(j);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]  <= cq << (4'd15 - lead);
            hi_reg[0] <= 5'd16 - {1'b0, lead};
            zf_reg[0] <= (cq == '0);
        end
    end

    // ---- log2 fraction by repeated squaring, one bit per stage
    for (genvar i = 0; i < SQ; i++)
    begin : g_sq
        logic [31:0] p;
        logic [16:0] ps;
        logic [15:0] fr_in;
        logic [15:0] fr_out;
        logic [15:0] z_out;

        if (i == 0)
        begin : g_f0
            assign fr_in = '0;
        end
        else
        begin : g_fn
            assign fr_in = fr_reg[i];
        end

        always_comb
        begin
            p      = 32'(z_reg[i]) * 32'(z_reg[i]);
            ps     = p[31:15];
            fr_out = fr_in;
            z_out  = ps[15:0];
            if (ps[16])
            begin
                z_out          = ps[16:1];
                fr_out[15 - i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fr_reg[i+1] <= fr_out;
                hi_reg[i+1] <= hi_reg[i];
                zf_reg[i+1] <= zf_reg[i];
            end
        end

        if (i < SQ - 1)
        begin : g_zp
            always_ff @(posedge clk)
            begin
                if (en)
                    z_reg[i+1] <= z_out;
            end
        end
    end

    // ---- negative log in Q.16
    logic [20:0] nl_reg;
    logic        nlz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_reg  <= {hi_reg[SQ], 16'd0} - {5'd0, fr_reg[SQ]};
            nlz_reg <= zf_reg[SQ];
        end
    end

    // ---- gamma: integer shift and fraction
    logic [36:0] t_prod;
    logic [4:0]  n_reg  [EXPN+1];
    logic [15:0] f_reg  [EXPN];
    logic        ez_reg [EXPN+1];
    logic [30:0] r_reg  [1:EXPN];

    assign t_prod = 37'(nl_reg) * 37'(gamma);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]  <= t_prod[34:30];
            f_reg[0]  <= t_prod[29:14];
            ez_reg[0] <= nlz_reg || (t_prod[36:30] >= 7'd31);
        end
    end

    // ---- exp2 of the fraction, one coefficient per stage
    for (genvar k = 0; k < EXPN; k++)
    begin : g_exp
        localparam logic [29:0] KC = htm_pkg::exp_coef(k);
        logic [30:0] r_in;
        logic [60:0] rp;

        if (k == 0)
        begin : g_r0
            assign r_in = 31'h4000_0000;
        end
        else
        begin : g_rn
            assign r_in = r_reg[k];
        end

        assign rp = 61'(r_in) * 61'(KC);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]  <= f_reg[k][15 - k] ? rp[60:30] : r_in;
                n_reg[k+1]  <= n_reg[k];
                ez_reg[k+1] <= ez_reg[k];
            end
        end

        if (k < EXPN - 1)
        begin : g_fp
            always_ff @(posedge clk)
            begin
                if (en)
                    f_reg[k+1] <= f_reg[k];
            end
        end
    end

    // ---- shift down and scale by 255
    logic [30:0] v;
    logic [38:0] w;
    logic [7:0]  y_reg;

    always_comb
    begin
        v = r_reg[EXPN] >> n_reg[EXPN];
        w = {v, 8'd0} - {8'd0, v};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= ez_reg[EXPN] ? 8'd0 : w[37:30];
    end

    assign y = y_reg;

endmodule
`default_nettype wire

/* rtl/core/htm_back.sv */
// htm_back: pulls classified items from the queue and runs the three channel
// pipelines in lock step into the output register. Depends on htm_pkg, htm_chan.
`timescale 1ns / 1ps
`default_nettype none
module htm_back #(
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire htm_pkg::item_t     head,
    input  wire htm_pkg::q_status_t q_st,
    output logic                    pop,
    input  wire logic [23:0]        scale,
    input  wire logic [15:0]        gamma,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output htm_pkg::pix_out_t       out_data
);

    localparam int LAT = htm_pkg::CH_LATENCY;

    logic       en;
    logic       vld_reg [LAT];
    logic       err_reg [LAT];
    logic [7:0] red_y;
    logic [7:0] green_y;
    logic [7:0] blue_y;

    // Freeze the whole pipeline only while a finished result is held
    assign en  = !(vld_reg[LAT-1] && out_stall);
    assign pop = en && !q_st.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pop;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg[0] <= head.neg;
            for (int i = 1; i < LAT; i++)
                err_reg[i] <= err_reg[i-1];
        end
    end

    htm_chan #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_red (
        .clk   (clk),
        .en    (en),
        .x     (head.red),
        .scale (scale),
        .gamma (gamma),
        .y     (red_y)
    );

    htm_chan #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_green (
        .clk   (clk),
        .en    (en),
        .x     (head.green),
        .scale (scale),
        .gamma (gamma),
        .y     (green_y)
    );

    htm_chan #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_blue (
        .clk   (clk),
        .en    (en),
        .x     (head.blue),
        .scale (scale),
        .gamma (gamma),
        .y     (blue_y)
    );

    assign out_valid             = vld_reg[LAT-1];
    assign out_data.red_out      = red_y;
    assign out_data.green_out    = green_y;
    assign out_data.blue_out     = blue_y;
    assign out_data.range_error  = err_reg[LAT-1];

endmodule
`default_nettype wire

/* rtl/core/hdr_tone_map_pixel.sv */
// hdr_tone_map_pixel: top level of the Reinhard tone mapper with gamma.
// Depends on htm_pkg, htm_front, htm_queue, htm_back (htm_chan).
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, in_data      | in
//   output  | out_valid, out_stall, out_data   | out
//   config  | cfg_we, cfg_index, cfg_data      | in
//
// One pixel per cycle sustained while out_stall stays low. A pixel passes the front
// register, the queue and the channel pipelines (16 divide stages, 16 squaring
// stages and 16 exp2 multiplier stages make up most of the channel depth).
// Reset clears all valid state and loads scale 1.0 and inverse gamma 1.0.
// An output stall on a valid result freezes the channel pipelines; the 4-entry
// queue and the front register then fill before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module hdr_tone_map_pixel #(
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire htm_pkg::pix_in_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output htm_pkg::pix_out_t                       out_data,
    input  wire logic                               cfg_we,
    input  wire logic [0:0]                         cfg_index,
    input  wire logic [htm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [23:0]        scale_reg;
    logic [23:0]        scale_next;
    logic [15:0]        gamma_reg;
    logic [15:0]        gamma_next;
    logic               q_push;
    logic               q_pop;
    htm_pkg::item_t     q_item;
    htm_pkg::item_t     q_head;
    htm_pkg::q_status_t q_st;

    // Decode register writes
    always_comb
    begin
        scale_next = scale_reg;
        gamma_next = gamma_reg;
        if (cfg_we)
        begin
            unique case (htm_pkg::cfg_reg_e'(cfg_index))
                htm_pkg::REG_SCALE: scale_next = cfg_data;
                htm_pkg::REG_GAMMA: gamma_next = cfg_data[15:0];
                default:            scale_next = scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 24'h01_0000;
            gamma_reg <= 16'h4000;
        end
        else
        begin
            scale_reg <= scale_next;
            gamma_reg <= gamma_next;
        end
    end

    htm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_st     (q_st),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    htm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .st        (q_st)
    );

    htm_back #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_st      (q_st),
        .pop       (q_pop),
        .scale     (scale_reg),
        .gamma     (gamma_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A flagged pixel carries zero channels
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.range_error) |->
        (out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
         out_data.blue_out == 8'd0))
        else $error("range_error with nonzero channel");

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_st.empty)
        else $error("queue popped while empty");

    // Never push into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_st.full)
        else $error("queue pushed while full");

    // A pop frees room, so the front can hand over next cycle
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_st.full)
        else $error("queue still full after pop");

endmodule
`default_nettype wire

/* tb/hdr_tone_map_pixel_test.sv */
// hdr_tone_map_pixel_test: self-checking testbench of the Reinhard tone mapper.
// Predicts every pixel in the testbench and checks the DUT output in order.
// Depends on htm_pkg and hdr_tone_map_pixel.
`timescale 1ns / 1ps
module hdr_tone_map_pixel_test;
    import htm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = CH_LATENCY + 16;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pix_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pix_out_t out_data;
    logic     cfg_we;
    logic [0:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hdr_tone_map_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: register copies and exp2 coefficients
    logic [23:0] gain_q;
    logic [15:0] gamma_q;
    logic [63:0] exp2_coef [16];

    pix_in_t  pixels_to_send [$];
    pix_out_t expected_pixels [$];
    logic     in_taken;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       cycles;
    bit       failed;

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Largest r with r*r <= v, found bit by bit from the top
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    // Scale, compress, gamma-correct and quantise one nonnegative channel
    function automatic logic [7:0] tone_channel(input logic [30:0] x);
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] z;
        logic [63:0] frac;
        logic [63:0] nl;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] level;
        int          e;
        int          i;
        s = (64'(x) * 64'(gain_q)) >> 16;
        if (s > 64'h7FFF_FFFF)
            s = 64'h7FFF_FFFF;
        c = (s << 16) / (s + 64'd65536);
        if (c == 0)
            return 8'd0;
        e = 15;
        while (e > 0 && c[e] == 1'b0)
            e--;
        z = c << (15 - e);
        frac = '0;
        for (i = 1; i <= 16; i++)
        begin
            z = (z * z) >> 15;
            if (z >= 64'd65536)
            begin
                z = z >> 1;
                frac[16 - i] = 1'b1;
            end
        end
        nl = (64'(16 - e) << 16) - frac;
        t = (nl * 64'(gamma_q)) >> 14;
        n = t >> 16;
        if (n >= 31)
            return 8'd0;
        r = 64'd1 << 30;
        for (i = 0; i < 16; i++)
        begin
            if (t[15 - i])
                r = (r * exp2_coef[i]) >> 30;
        end
        r = r >> n;
        level = (64'd255 * r) >> 30;
        return level[7:0];
    endfunction

    function automatic pix_out_t tone_map_pixel(input pix_in_t p);
        pix_out_t o;
        o = '0;
        if (p.red_in[31] || p.green_in[31] || p.blue_in[31])
        begin
            o.range_error = 1'b1;
            return o;
        end
        o.red_out   = tone_channel(p.red_in[30:0]);
        o.green_out = tone_channel(p.green_in[30:0]);
        o.blue_out  = tone_channel(p.blue_in[30:0]);
        return o;
    endfunction

    // Random channel: mostly modest magnitudes, some negative, full range and extremes
    function automatic logic [31:0] random_channel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return 32'h8000_0000 | $urandom;
        else if (pick < 45)
            return $urandom_range(0, 32'h0002_0000);
        else if (pick < 75)
            return $urandom >> $urandom_range(1, 31);
        else if (pick < 92)
            return {1'b0, 31'($urandom)};
        else if (pick < 96)
            return $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        p.red_in   = random_channel();
        p.green_in = random_channel();
        p.blue_in  = random_channel();
        return p;
    endfunction

    // Drive pixels and output stall on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pixels_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Record accepted pixels, register writes and check results
    always @(posedge clk)
    begin
        pix_out_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hdr_tone_map_pixel_test: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_pixels.insert(expected_pixels.size(), tone_map_pixel(in_data));
            if (cfg_we)
            begin
                if (cfg_index == REG_SCALE)
                    gain_q <= cfg_data[23:0];
                else
                    gamma_q <= cfg_data[15:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel out: %h", out_data);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.red_out !== want.red_out)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red_out, out_data.red_out);
                        failed = 1'b1;
                    end
                    if (out_data.green_out !== want.green_out)
                    begin
                        $error("green_out: expected %0d, got %0d",
                               want.green_out, out_data.green_out);
                        failed = 1'b1;
                    end
                    if (out_data.blue_out !== want.blue_out)
                    begin
                        $error("blue_out: expected %0d, got %0d",
                               want.blue_out, out_data.blue_out);
                        failed = 1'b1;
                    end
                    if (out_data.range_error !== want.range_error)
                    begin
                        $error("range_error: expected %0d, got %0d",
                               want.range_error, out_data.range_error);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Hold until every pixel is sent and every result has come
    task automatic wait_drained();
        while (pixels_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [23:0] gain, input logic [15:0] gam,
                             input int idle_pct, input int stall_pct, input int count);
        int k;
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        write_reg(REG_SCALE, gain);
        write_reg(REG_GAMMA, 24'(gam));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
            pixels_to_send.insert(pixels_to_send.size(), random_pixel());
    endtask

    initial
    begin
        pix_in_t p;
        int      k;
        failed         = 1'b0;
        cycles         = 0;
        in_taken       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gain_q         = 24'd65536;
        gamma_q        = 16'd16384;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SCALE;
        cfg_data       = '0;
        exp2_coef[0] = floor_sqrt(64'd1 << 59);
        for (k = 1; k < 16; k++)
            exp2_coef[k] = floor_sqrt(exp2_coef[k - 1] << 30);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed pixels at the reset setting: extremes, zero, negatives
        p = '{32'sd0, 32'sd1, 32'sd65536};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sd0, 32'sd0, 32'sd0};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{-32'sd1, 32'sd100, 32'sd100};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sd100, 32'sh8000_0000, 32'sd100};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sd100, 32'sd100, -32'sd65536};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sd32768, 32'sd131072, 32'sd2};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sd16777216, 32'sd255, 32'sh5555_5555};
        pixels_to_send.insert(pixels_to_send.size(), p);
        p = '{32'sh2AAA_AAAA, 32'sd3, 32'sd65535};
        pixels_to_send.insert(pixels_to_send.size(), p);
        for (k = 0; k < 11; k++)
            pixels_to_send.insert(pixels_to_send.size(), random_pixel());

        // Settings including the register extremes and a zero gamma
        run_phase(24'd65536, 16'd16384, 0, 0, 20);
        run_phase(24'hFF_FFFF, 16'hFFFF, 87, 0, 70);
        run_phase(24'd0, 16'd0, 0, 87, 40);
        run_phase(24'd1, 16'd0, 30, 30, 30);
        run_phase(24'($urandom_range(1, 24'hFF_FFFF)), 16'd1, 30, 30, 70);
        run_phase(24'd16384, 16'd9362, 0, 0, 70);
        run_phase(24'($urandom_range(1, 24'h04_0000)), 16'($urandom_range(1, 65535)),
                  87, 0, 40);
        run_phase(24'd65536, 16'd16384, 0, 87, 40);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (!failed && expected_pixels.size() == 0)
            $display("hdr_tone_map_pixel_test: PASS");
        else
            $display("hdr_tone_map_pixel_test: FAIL");
        $finish;
    end

endmodule
